>>> sv/qrr_pkg.sv
// ============================================================================
// qrr_pkg: shared types and constants for the quadratic real-root solver
// Widths of the fixed-point datapath, the root-class codes, and the records
// that travel along the square-root and divider cell chains.
// ============================================================================
package qrr_pkg;

    // Coefficient format: signed, COEF_WIDTH bits, FRAC_BITS fraction bits
    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Magnitude of a coefficient (holds 2^(COEF_WIDTH-1))
    localparam int MAG_W    = COEF_WIDTH;
    localparam int PROD_W   = 2 * MAG_W;
    // Discriminant b^2 + 4ac worst case, kept even for two-bit sqrt digits
    localparam int DISC_W   = PROD_W + 2;
    localparam int SQRT_STEPS = DISC_W / 2;
    localparam int ROOT_W   = SQRT_STEPS;
    localparam int SQ_REM_W = ROOT_W + 3;
    // |b| + sqrt(d)
    localparam int RMAG_W   = ROOT_W + 1;
    localparam int DEN_W    = RMAG_W;
    localparam int NUM_W    = RMAG_W + FRAC_BITS;

    // Stream widths, padded to whole bytes
    localparam int TDATA_IN_W  = ((5 * COEF_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((2 + 2 * COEF_WIDTH + 7) / 8) * 8;

    // Root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_ALL  = 2'd3;

    // Saturation limits for quotient magnitudes
    localparam logic [NUM_W-1:0] SAT_POS =
        {{(NUM_W-COEF_WIDTH+1){1'b0}}, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [NUM_W-1:0] SAT_NEG =
        {{(NUM_W-COEF_WIDTH){1'b0}}, 1'b1, {(COEF_WIDTH-1){1'b0}}};

    // What kind of solution an item has before interval filtering
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_ALL,
        CLS_LINEAR,
        CLS_DOUBLE,
        CLS_TWO
    } root_class_t;

    // Per-item sideband carried down the pipeline
    typedef struct packed {
        logic                          kind;
        root_class_t                   cls;
        logic                          sa;
        logic                          sb;
        logic                          sc;
        logic [MAG_W-1:0]              ma;
        logic [MAG_W-1:0]              mb;
        logic [MAG_W-1:0]              mc;
        logic signed [COEF_WIDTH-1:0]  low;
        logic signed [COEF_WIDTH-1:0]  high;
        logic                          neg1;
        logic                          neg2;
    } side_t;

    // Square-root cell state
    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [DISC_W-1:0]   rad;
    } sq_lane_t;

    // Divider cell state, one lane
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
    } dv_lane_t;

    // Saturated roots ahead of sorting and filtering
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] r1;
        logic signed [COEF_WIDTH-1:0] r2;
        logic                         ovf;
        root_class_t                  cls;
        logic                         kind;
        logic signed [COEF_WIDTH-1:0] low;
        logic signed [COEF_WIDTH-1:0] high;
    } res_t;

    // Magnitude of a two's complement coefficient
    function automatic logic [MAG_W-1:0] mag_of(input logic [COEF_WIDTH-1:0] x);
        logic [MAG_W-1:0] m;
        m = x[COEF_WIDTH-1] ? MAG_W'(-x) : MAG_W'(x);
        return m;
    endfunction

endpackage

>>> sv/qrr_sqrt_cell.sv
// ============================================================================
// qrr_sqrt_cell: one digit of the integer square root
// Takes the next two radicand bits, tries root digit one, and hands the
// partial root, remainder and remaining radicand to the next cell.
// ============================================================================
module qrr_sqrt_cell
    import qrr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  sq_lane_t in_lane,
    input  side_t    in_side,
    output logic     out_valid,
    output sq_lane_t out_lane,
    output side_t    out_side
);

    logic     valid_reg;
    sq_lane_t lane_reg;
    side_t    side_reg;
    sq_lane_t lane_next;

    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;

    // Restoring digit step
    always_comb
    begin
        rem_sh = {in_lane.rem[SQ_REM_W-3:0], in_lane.rad[DISC_W-1 -: 2]};
        trial  = SQ_REM_W'({in_lane.root, 2'b01});
        lane_next.rad = {in_lane.rad[DISC_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            lane_next.rem  = rem_sh - trial;
            lane_next.root = {in_lane.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = rem_sh;
            lane_next.root = {in_lane.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
    assign out_side  = side_reg;

endmodule

>>> sv/qrr_div_cell.sv
// ============================================================================
// qrr_div_cell: one quotient bit of two restoring dividers
// Both lanes shift in one numerator bit, compare against the divisor and
// pass remainder and partial quotient to the next cell.
// ============================================================================
module qrr_div_cell
    import qrr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  dv_lane_t in_l1,
    input  dv_lane_t in_l2,
    input  side_t    in_side,
    output logic     out_valid,
    output dv_lane_t out_l1,
    output dv_lane_t out_l2,
    output side_t    out_side
);

    logic     valid_reg;
    dv_lane_t l1_reg;
    dv_lane_t l2_reg;
    side_t    side_reg;
    dv_lane_t l1_next;
    dv_lane_t l2_next;

    function automatic dv_lane_t div_step(input dv_lane_t l);
        dv_lane_t      r;
        logic [DEN_W:0] rem_sh;
        logic [DEN_W:0] diff;
        rem_sh = {l.rem, l.num[NUM_W-1]};
        diff   = rem_sh - {1'b0, l.den};
        r.den  = l.den;
        r.num  = {l.num[NUM_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, l.den})
        begin
            r.rem = diff[DEN_W-1:0];
            r.quo = {l.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = rem_sh[DEN_W-1:0];
            r.quo = {l.quo[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One bit per lane
    always_comb
    begin
        l1_next = div_step(in_l1);
        l2_next = div_step(in_l2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg   <= l1_next;
            l2_reg   <= l2_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_l1    = l1_reg;
    assign out_l2    = l2_reg;
    assign out_side  = side_reg;

endmodule

>>> sv/quadratic_real_root_solver.sv
// ============================================================================
// quadratic_real_root_solver: real roots of a*x^2 + b*x + c in Q16.16
// Pipelined solver built from a chain of square-root cells and a chain of
// dual divider cells; one result per query, sorted ascending.
// ============================================================================
// Usage:
//   Slave channel: one transfer per query. tdata carries a, b, c, low, high;
//   tuser selects all roots (0) or only roots inside [low, high] (1).
//   Master channel: one transfer per query, in query order. tdata carries
//   root count, smaller root and larger root; tuser flags saturation.
// Pipeline path from slave transfer to master tvalid: 3 front stages,
//   one sqrt cell per root bit, a setup stage, one divider cell per
//   quotient bit, a saturation stage and the output register.
// Throughput: one query per cycle unless frozen by a master stall; each
//   cell handles one item at a time and passes it on to the next cell.
// Reset: clears all valid bits; the pipeline comes up empty and ready.
// Stall: while the master side stalls, the held result stays in the output
//   register and the pipeline keeps moving and accepting queries until a
//   finished result reaches the last stage; then all stages freeze and
//   s_tready drops until the held result is taken.
// ============================================================================
module quadratic_real_root_solver
    import qrr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // coef_a, coef_b, coef_c, interval_low, interval_high
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // kind
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // root_count, root_first, root_second, zero pad
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // overflow
    output logic                   m_tuser
);

    logic adv;

    // ---------------------------------------------------------------- stage 1
    logic  st1_valid_reg;
    side_t st1_side_reg;
    side_t st1_side_next;

    always_comb
    begin
        st1_side_next      = '0;
        st1_side_next.kind = s_tuser;
        st1_side_next.cls  = CLS_NONE;
        st1_side_next.sa   = s_tdata[COEF_WIDTH-1];
        st1_side_next.sb   = s_tdata[2*COEF_WIDTH-1];
        st1_side_next.sc   = s_tdata[3*COEF_WIDTH-1];
        st1_side_next.ma   = mag_of(s_tdata[0 +: COEF_WIDTH]);
        st1_side_next.mb   = mag_of(s_tdata[COEF_WIDTH +: COEF_WIDTH]);
        st1_side_next.mc   = mag_of(s_tdata[2*COEF_WIDTH +: COEF_WIDTH]);
        st1_side_next.low  = s_tdata[3*COEF_WIDTH +: COEF_WIDTH];
        st1_side_next.high = s_tdata[4*COEF_WIDTH +: COEF_WIDTH];
    end

    // ---------------------------------------------------------------- stage 2
    logic              st2_valid_reg;
    side_t             st2_side_reg;
    logic [PROD_W-1:0] st2_p_reg;
    logic [PROD_W-1:0] st2_q_reg;
    logic [PROD_W-1:0] st2_p_next;
    logic [PROD_W-1:0] st2_q_next;

    // b^2 and a*c
    assign st2_p_next = PROD_W'(st1_side_reg.mb) * PROD_W'(st1_side_reg.mb);
    assign st2_q_next = PROD_W'(st1_side_reg.ma) * PROD_W'(st1_side_reg.mc);

    // ---------------------------------------------------------------- stage 3
    logic              st3_valid_reg;
    side_t             st3_side_reg;
    logic [DISC_W-1:0] st3_d_reg;
    side_t             st3_side_next;
    logic [DISC_W-1:0] st3_d_next;
    logic [DISC_W-1:0] p_ext;
    logic [DISC_W-1:0] q_ext;
    logic              disc_neg;

    // Discriminant and solution class
    always_comb
    begin
        p_ext         = DISC_W'(st2_p_reg);
        q_ext         = {st2_q_reg, 2'b00};
        disc_neg      = 1'b0;
        st3_side_next = st2_side_reg;
        if (st2_side_reg.sa != st2_side_reg.sc)
        begin
            st3_d_next = p_ext + q_ext;
        end
        else
        begin
            st3_d_next = p_ext - q_ext;
            disc_neg   = (p_ext < q_ext);
        end
        if (st2_side_reg.ma == '0)
        begin
            if (st2_side_reg.mb == '0)
            begin
                st3_side_next.cls = (st2_side_reg.mc == '0) ? CLS_ALL : CLS_NONE;
            end
            else
            begin
                st3_side_next.cls = CLS_LINEAR;
            end
        end
        else if (disc_neg)
        begin
            st3_side_next.cls = CLS_NONE;
        end
        else if (st3_d_next == '0)
        begin
            st3_side_next.cls = CLS_DOUBLE;
        end
        else
        begin
            st3_side_next.cls = CLS_TWO;
        end
    end

    // ------------------------------------------------------- sqrt cell chain
    logic     sq_valid [SQRT_STEPS+1];
    sq_lane_t sq_lane  [SQRT_STEPS+1];
    side_t    sq_side  [SQRT_STEPS+1];

    assign sq_valid[0]     = st3_valid_reg;
    assign sq_lane[0].rem  = '0;
    assign sq_lane[0].root = '0;
    assign sq_lane[0].rad  = st3_d_reg;
    assign sq_side[0]      = st3_side_reg;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        qrr_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (sq_valid[i]),
            .in_lane   (sq_lane[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_lane  (sq_lane[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // ---------------------------------------------------------------- stage 4
    logic              st4_valid_reg;
    side_t             st4_side_reg;
    dv_lane_t          st4_l1_reg;
    dv_lane_t          st4_l2_reg;
    side_t             st4_side_next;
    dv_lane_t          st4_l1_next;
    dv_lane_t          st4_l2_next;
    logic [RMAG_W-1:0] rmag;
    logic              rneg;
    logic [RMAG_W-1:0] n1;
    logic [RMAG_W-1:0] n2;
    logic [DEN_W-1:0]  d1;
    logic [DEN_W-1:0]  d2;
    side_t             sq_last;

    // Divider operands per solution class
    always_comb
    begin
        sq_last       = sq_side[SQRT_STEPS];
        st4_side_next = sq_last;
        rmag = RMAG_W'(sq_last.mb) + RMAG_W'(sq_lane[SQRT_STEPS].root);
        rneg = !sq_last.sb && (sq_last.mb != '0);
        n1   = '0;
        n2   = '0;
        d1   = DEN_W'(1);
        d2   = DEN_W'(1);
        st4_side_next.neg1 = 1'b0;
        st4_side_next.neg2 = 1'b0;
        case (sq_last.cls)
            CLS_LINEAR:
            begin
                n1 = RMAG_W'(sq_last.mc);
                d1 = DEN_W'(sq_last.mb);
                st4_side_next.neg1 = (sq_last.sc == sq_last.sb);
            end
            CLS_DOUBLE:
            begin
                n1 = RMAG_W'(sq_last.mb);
                d1 = DEN_W'({sq_last.ma, 1'b0});
                st4_side_next.neg1 = (sq_last.sa == sq_last.sb);
            end
            CLS_TWO:
            begin
                n1 = rmag;
                d1 = DEN_W'({sq_last.ma, 1'b0});
                n2 = RMAG_W'({sq_last.mc, 1'b0});
                d2 = rmag;
                st4_side_next.neg1 = (rneg != sq_last.sa);
                st4_side_next.neg2 = (sq_last.sc != rneg);
            end
            default:
            begin
                n1 = '0;
            end
        endcase
        st4_l1_next.rem = '0;
        st4_l1_next.den = d1;
        st4_l1_next.num = {n1, {FRAC_BITS{1'b0}}};
        st4_l1_next.quo = '0;
        st4_l2_next.rem = '0;
        st4_l2_next.den = d2;
        st4_l2_next.num = {n2, {FRAC_BITS{1'b0}}};
        st4_l2_next.quo = '0;
    end

    // ---------------------------------------------------- divider cell chain
    logic     dv_valid [NUM_W+1];
    dv_lane_t dv_l1    [NUM_W+1];
    dv_lane_t dv_l2    [NUM_W+1];
    side_t    dv_side  [NUM_W+1];

    assign dv_valid[0] = st4_valid_reg;
    assign dv_l1[0]    = st4_l1_reg;
    assign dv_l2[0]    = st4_l2_reg;
    assign dv_side[0]  = st4_side_reg;

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_div
        qrr_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (dv_valid[j]),
            .in_l1     (dv_l1[j]),
            .in_l2     (dv_l2[j]),
            .in_side   (dv_side[j]),
            .out_valid (dv_valid[j+1]),
            .out_l1    (dv_l1[j+1]),
            .out_l2    (dv_l2[j+1]),
            .out_side  (dv_side[j+1])
        );
    end

    // ---------------------------------------------------------------- stage 5
    logic             st5_valid_reg;
    res_t             st5_res_reg;
    res_t             st5_res_next;
    side_t            dv_last;
    logic [NUM_W-1:0] lim1;
    logic [NUM_W-1:0] lim2;
    logic [NUM_W-1:0] qs1;
    logic [NUM_W-1:0] qs2;
    logic             sat1;
    logic             sat2;
    logic             use1;
    logic             use2;

    // Clamp quotients to the signed range and apply signs
    always_comb
    begin
        dv_last = dv_side[NUM_W];
        lim1 = dv_last.neg1 ? SAT_NEG : SAT_POS;
        lim2 = dv_last.neg2 ? SAT_NEG : SAT_POS;
        sat1 = (dv_l1[NUM_W].quo > lim1);
        sat2 = (dv_l2[NUM_W].quo > lim2);
        qs1  = sat1 ? lim1 : dv_l1[NUM_W].quo;
        qs2  = sat2 ? lim2 : dv_l2[NUM_W].quo;
        use1 = (dv_last.cls == CLS_LINEAR) || (dv_last.cls == CLS_DOUBLE) ||
               (dv_last.cls == CLS_TWO);
        use2 = (dv_last.cls == CLS_TWO);
        st5_res_next.r1 = dv_last.neg1 ? -$signed(qs1[COEF_WIDTH-1:0])
                                       : $signed(qs1[COEF_WIDTH-1:0]);
        st5_res_next.r2 = dv_last.neg2 ? -$signed(qs2[COEF_WIDTH-1:0])
                                       : $signed(qs2[COEF_WIDTH-1:0]);
        st5_res_next.ovf  = (use1 && sat1) || (use2 && sat2);
        st5_res_next.cls  = dv_last.cls;
        st5_res_next.kind = dv_last.kind;
        st5_res_next.low  = dv_last.low;
        st5_res_next.high = dv_last.high;
    end

    // --------------------------------------------------------- output stage
    logic                         out_valid_reg;
    logic [1:0]                   out_count_reg;
    logic signed [COEF_WIDTH-1:0] out_first_reg;
    logic signed [COEF_WIDTH-1:0] out_second_reg;
    logic                         out_ovf_reg;
    logic [1:0]                   out_count_next;
    logic signed [COEF_WIDTH-1:0] out_first_next;
    logic signed [COEF_WIDTH-1:0] out_second_next;
    logic                         out_valid_next;
    logic signed [COEF_WIDTH-1:0] lo_r;
    logic signed [COEF_WIDTH-1:0] hi_r;
    logic                         out_lo;
    logic                         out_hi;

    // Sort, interval filter and clear unused roots
    always_comb
    begin
        if ((st5_res_reg.cls == CLS_TWO) && (st5_res_reg.r1 > st5_res_reg.r2))
        begin
            lo_r = st5_res_reg.r2;
            hi_r = st5_res_reg.r1;
        end
        else
        begin
            lo_r = st5_res_reg.r1;
            hi_r = st5_res_reg.r2;
        end
        case (st5_res_reg.cls) inside
            CLS_ALL:                out_count_next = CNT_ALL;
            CLS_LINEAR, CLS_DOUBLE: out_count_next = CNT_ONE;
            CLS_TWO:                out_count_next = CNT_TWO;
            default:                out_count_next = CNT_NONE;
        endcase
        out_lo = (lo_r < st5_res_reg.low) || (lo_r > st5_res_reg.high);
        out_hi = (hi_r < st5_res_reg.low) || (hi_r > st5_res_reg.high);
        out_first_next  = lo_r;
        out_second_next = hi_r;
        if (st5_res_reg.kind)
        begin
            if (out_count_next == CNT_ONE)
            begin
                if (out_lo)
                begin
                    out_count_next = CNT_NONE;
                end
                else
                begin
                    out_count_next  = CNT_TWO;
                    out_second_next = lo_r;
                end
            end
            else if (out_count_next == CNT_TWO)
            begin
                if (out_lo && out_hi)
                begin
                    out_count_next = CNT_NONE;
                end
                else if (out_lo)
                begin
                    out_count_next = CNT_ONE;
                    out_first_next = hi_r;
                end
                else if (out_hi)
                begin
                    out_count_next = CNT_ONE;
                end
            end
        end
        if ((out_count_next == CNT_NONE) || (out_count_next == CNT_ALL))
        begin
            out_first_next  = '0;
            out_second_next = '0;
        end
        else if (out_count_next == CNT_ONE)
        begin
            out_second_next = '0;
        end
    end

    // Pipeline moves unless a finished result would overrun a held one
    assign adv = !(st5_valid_reg && out_valid_reg && !m_tready);

    always_comb
    begin
        if (adv && st5_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                st1_valid_reg <= s_tvalid;
                st2_valid_reg <= st1_valid_reg;
                st3_valid_reg <= st2_valid_reg;
                st4_valid_reg <= sq_valid[SQRT_STEPS];
                st5_valid_reg <= dv_valid[NUM_W];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_side_reg <= st1_side_next;
            st2_side_reg <= st1_side_reg;
            st2_p_reg    <= st2_p_next;
            st2_q_reg    <= st2_q_next;
            st3_side_reg <= st3_side_next;
            st3_d_reg    <= st3_d_next;
            st4_side_reg <= st4_side_next;
            st4_l1_reg   <= st4_l1_next;
            st4_l2_reg   <= st4_l2_next;
            st5_res_reg  <= st5_res_next;
        end
        if (adv && st5_valid_reg)
        begin
            out_count_reg  <= out_count_next;
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_ovf_reg    <= st5_res_reg.ovf;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ovf_reg;
    assign m_tdata  = {{(TDATA_OUT_W-2-2*COEF_WIDTH){1'b0}},
                       out_second_reg, out_first_reg, out_count_reg};

`ifndef NO_ASSERTIONS
    // No roots or every x a root: both root words are zero
    a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_count_reg == CNT_NONE) || (out_count_reg == CNT_ALL))
        |-> (out_first_reg == '0) && (out_second_reg == '0))
        else $error("root words not cleared");

    // Single root: larger root word is zero
    a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_count_reg == CNT_ONE) |-> (out_second_reg == '0))
        else $error("second root not cleared");

    // Two roots come out sorted
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_count_reg == CNT_TWO) |-> (out_first_reg <= out_second_reg))
        else $error("roots out of order");

    // A stalled pipeline keeps its last-stage result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> st5_valid_reg && $stable(st5_res_reg))
        else $error("last stage changed while frozen");
`endif

endmodule

>>> tb/quadratic_real_root_solver_tb.sv
// ============================================================================
// quadratic_real_root_solver_tb: self-checking bench for the root solver
// Streams directed and random quadratic queries through the slave channel,
// predicts each result with exact wide-integer arithmetic, and checks the
// master channel in order under varying source idle and sink stall rates.
// ============================================================================
module quadratic_real_root_solver_tb;
    import qrr_pkg::*;

    typedef struct {
        bit                   kind;
        logic [COEF_WIDTH-1:0] a, b, c, lo, hi;
    } query_t;

    typedef struct {
        logic [1:0]            cnt;
        logic [COEF_WIDTH-1:0] first, second;
        bit                    ovf;
    } roots_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;

    query_t query_q[$];
    roots_t roots_due_q[$];
    int     send_idle_pct;
    int     sink_stall_pct;
    bit     sink_hold;
    bit     took;
    int     mismatches;

    quadratic_real_root_solver u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Floor square root of a wide value
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [127:0] cand;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = {64'd0, r | (64'd1 << i)};
            if (cand * cand <= v)
                r = cand[63:0];
        end
        return r;
    endfunction

    // Truncated Q16.16 quotient with saturation
    function automatic longint fix_div(input bit neg, input logic [127:0] num,
                                       input logic [127:0] den, inout bit ovf);
        logic [127:0] q;
        logic [127:0] limit;
        limit = (128'd1 << (COEF_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
        if (den == 0)
            return 0;
        q = (num << FRAC_BITS) / den;
        if (q > limit)
        begin
            ovf = 1'b1;
            q = limit;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // Expected roots of one query
    function automatic roots_t solve_quadratic(input query_t qy);
        roots_t       res;
        bit           sa, sb, sc, ovf, rneg, out1, out2;
        logic [127:0] ma, mb, mc, p, q4, d, rmag;
        longint       r1, r2, lo, hi, t;
        int           cnt;
        sa = qy.a[COEF_WIDTH-1];
        sb = qy.b[COEF_WIDTH-1];
        sc = qy.c[COEF_WIDTH-1];
        ma = {96'd0, sa ? -qy.a : qy.a};
        mb = {96'd0, sb ? -qy.b : qy.b};
        mc = {96'd0, sc ? -qy.c : qy.c};
        ovf = 1'b0;
        r1 = 0;
        r2 = 0;
        if (ma == 0)
        begin
            if (mb == 0)
                cnt = (mc == 0) ? -1 : 0;
            else
            begin
                cnt = 1;
                r1 = fix_div(sc == sb, mc, mb, ovf);
            end
        end
        else
        begin
            p  = mb * mb;
            q4 = (ma * mc) << 2;
            if (sa != sc)
                d = p + q4;
            else if (p < q4)
                d = '1;
            else
                d = p - q4;
            if (d == '1)
                cnt = 0;
            else if (d == 0)
            begin
                cnt = 1;
                r1 = fix_div(sa == sb, mb, 2 * ma, ovf);
            end
            else
            begin
                rneg = !sb && mb != 0;
                rmag = mb + floor_sqrt(d);
                cnt = 2;
                r1 = fix_div(rneg != sa, rmag, 2 * ma, ovf);
                r2 = fix_div(sc != rneg, 2 * mc, rmag, ovf);
                if (r1 > r2)
                begin
                    t = r1;
                    r1 = r2;
                    r2 = t;
                end
            end
        end
        // Interval filter
        if (qy.kind)
        begin
            lo = longint'(signed'(qy.lo));
            hi = longint'(signed'(qy.hi));
            if (cnt == 1)
            begin
                if (r1 < lo || r1 > hi)
                    cnt = 0;
                else
                begin
                    cnt = 2;
                    r2 = r1;
                end
            end
            else if (cnt == 2)
            begin
                out2 = (r2 < lo || r2 > hi);
                out1 = (r1 < lo || r1 > hi);
                if (out2)
                    cnt--;
                if (out1)
                begin
                    r1 = r2;
                    cnt--;
                end
            end
        end
        if (cnt <= 0)
        begin
            r1 = 0;
            r2 = 0;
        end
        else if (cnt == 1)
            r2 = 0;
        case (cnt)
            -1:      res.cnt = CNT_ALL;
            1:       res.cnt = CNT_ONE;
            2:       res.cnt = CNT_TWO;
            default: res.cnt = CNT_NONE;
        endcase
        res.first  = r1[COEF_WIDTH-1:0];
        res.second = r2[COEF_WIDTH-1:0];
        res.ovf    = ovf;
        return res;
    endfunction

    // Random coefficient: moderate values half the time, else full range or corners
    function automatic logic [COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {1'b1, {(COEF_WIDTH-1){1'b0}}};
            2:       return {1'b0, {(COEF_WIDTH-1){1'b1}}};
            3, 4:    return $urandom();
            5:       return $urandom_range(1, 3) << FRAC_BITS;
            default: return $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        endcase
    endfunction

    function automatic query_t make_query(input bit kind, input int a, input int b,
                                          input int c, input int lo, input int hi);
        query_t qy;
        qy.kind = kind;
        qy.a = a;
        qy.b = b;
        qy.c = c;
        qy.lo = lo;
        qy.hi = hi;
        return qy;
    endfunction

    // Random query; often built from chosen roots so that intervals matter
    function automatic query_t random_query();
        query_t qy;
        int     k, x1, x2;
        qy.kind = $urandom_range(1);
        if ($urandom_range(2) == 0)
        begin
            // a = k, roots x1, x2 in whole units
            k  = $urandom_range(1, 4) * (($urandom_range(1)) ? 1 : -1);
            x1 = $urandom_range(0, 200) - 100;
            x2 = $urandom_range(0, 200) - 100;
            qy.a = k << FRAC_BITS;
            qy.b = (-k * (x1 + x2)) << FRAC_BITS;
            qy.c = (k * x1 * x2) << FRAC_BITS;
            qy.lo = ($urandom_range(0, 240) - 120) << FRAC_BITS;
            qy.hi = ($urandom_range(0, 240) - 120) << FRAC_BITS;
        end
        else
        begin
            qy.a = pick_coef();
            qy.b = pick_coef();
            qy.c = pick_coef();
            qy.lo = ($urandom_range(3) == 0) ? $urandom() : pick_coef();
            qy.hi = ($urandom_range(3) == 0) ? $urandom() : pick_coef();
        end
        return qy;
    endfunction

    // Source: drive queries at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || took)
        begin
            if (query_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                query_t qy;
                qy = query_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= qy.kind;
                s_tdata  <= {qy.hi, qy.lo, qy.c, qy.b, qy.a};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sink: random stalls, plus the long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // Input side: predict each accepted query
    always @(posedge clk)
    begin
        took <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            roots_due_q.push_back(solve_quadratic(make_query(s_tuser,
                s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                s_tdata[127:96], s_tdata[159:128])));
    end

    // Output side: check each result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (roots_due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: count=%0d first=%h second=%h ovf=%b",
                             m_tdata[1:0], m_tdata[33:2], m_tdata[65:34], m_tuser);
            end
            else
            begin
                roots_t exp_r;
                exp_r = roots_due_q.pop_front();
                if (m_tdata[1:0] !== exp_r.cnt || m_tdata[33:2] !== exp_r.first ||
                    m_tdata[65:34] !== exp_r.second || m_tuser !== exp_r.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp cnt=%0d %h %h ovf=%b, got cnt=%0d %h %h ovf=%b",
                                 exp_r.cnt, exp_r.first, exp_r.second, exp_r.ovf,
                                 m_tdata[1:0], m_tdata[33:2], m_tdata[65:34], m_tuser);
                end
            end
        end
    end

    // Long sink hold-off while the source keeps pushing
    initial
    begin
        sink_hold = 1'b0;
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
    end

    // Hard limit
    initial
    begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        localparam int ONE = 1 << FRAC_BITS;
        int idle_plan[4][2];
        send_idle_pct = 0;
        sink_stall_pct = 0;
        idle_plan = '{'{0, 0}, '{73, 0}, '{0, 73}, '{26, 26}};

        // Directed corners
        query_q.push_back(make_query(0, 0, 0, 0, 0, 0));                   // all x
        query_q.push_back(make_query(1, 0, 0, 0, ONE, -ONE));              // all x, interval
        query_q.push_back(make_query(0, 0, 0, 5 * ONE, 0, 0));             // constant
        query_q.push_back(make_query(0, 0, 2 * ONE, -4 * ONE, 0, 0));      // linear
        query_q.push_back(make_query(0, 0, 1, 32'h7fffffff, 0, 0));        // linear, saturates
        query_q.push_back(make_query(0, 0, 32'h80000000, 32'h80000000, 0, 0));
        query_q.push_back(make_query(0, ONE, -2 * ONE, ONE, 0, 0));        // double root
        query_q.push_back(make_query(0, ONE, 0, ONE, 0, 0));               // no real root
        query_q.push_back(make_query(0, ONE, -3 * ONE, 2 * ONE, 0, 0));    // b negative
        query_q.push_back(make_query(0, ONE, 3 * ONE, 2 * ONE, 0, 0));     // b positive
        query_q.push_back(make_query(0, -ONE, 0, 4 * ONE, 0, 0));          // b zero
        query_q.push_back(make_query(0, 1, 32'h7fffffff, 1, 0, 0));        // overflow
        query_q.push_back(make_query(0, 32'h80000000, 32'h7fffffff,
                                     32'h80000000, 0, 0));
        query_q.push_back(make_query(0, 32'h7fffffff, 32'h80000000,
                                     32'h80000000, 0, 0));
        query_q.push_back(make_query(1, 0, 2 * ONE, -4 * ONE, 0, 3 * ONE)); // one in
        query_q.push_back(make_query(1, 0, 2 * ONE, -4 * ONE, 3 * ONE, 9 * ONE)); // one out
        query_q.push_back(make_query(1, ONE, -2 * ONE, ONE, ONE, ONE));    // double, edge
        query_q.push_back(make_query(1, ONE, -3 * ONE, 2 * ONE, 0, 3 * ONE)); // both in
        query_q.push_back(make_query(1, ONE, -3 * ONE, 2 * ONE, 0, ONE));  // lower only
        query_q.push_back(make_query(1, ONE, -3 * ONE, 2 * ONE, 2 * ONE, 5 * ONE)); // upper
        query_q.push_back(make_query(1, ONE, -3 * ONE, 2 * ONE, 3 * ONE, 0)); // inverted
        query_q.push_back(make_query(1, ONE, -3 * ONE, 2 * ONE,
                                     32'h80000000, 32'h7fffffff));
        query_q.push_back(make_query(1, -1, -1, -1, -1, -1));

        @(posedge rst_n);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_plan[ph][0];
            sink_stall_pct = idle_plan[ph][1];
            for (int i = 0; i < 257; i++)
                query_q.push_back(random_query());
            while (query_q.size() > 0 || s_tvalid)
                @(posedge clk);
        end

        while (roots_due_q.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (mismatches == 0 && roots_due_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
sv/qrr_pkg.sv
sv/qrr_sqrt_cell.sv
sv/qrr_div_cell.sv
sv/quadratic_real_root_solver.sv
tb/quadratic_real_root_solver_tb.sv
